FILE: src/sng_pkg.sv
// Shared types, constants and register codes for the stereo noise gate.
package sng_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int HOLD_BITS_DEF   = 21;

  localparam int GAIN_W     = 17;
  localparam int THR_W      = 16;
  localparam int HOLD_CFG_W = 20;
  localparam int DECAY_W    = 16;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 3;

  localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GATE_ENABLE     = 3'd0,
    REG_OPEN_THRESHOLD  = 3'd1,
    REG_CLOSE_THRESHOLD = 3'd2,
    REG_ATTACK_STEP     = 3'd3,
    REG_RELEASE_STEP    = 3'd4,
    REG_HOLD_SAMPLES    = 3'd5,
    REG_DECAY_STEP      = 3'd6
  } sng_reg_t;

  typedef struct packed {
    logic                  gate_enable;
    logic [THR_W-1:0]      open_threshold;
    logic [THR_W-1:0]      close_threshold;
    logic [GAIN_W-1:0]     attack_step;
    logic [GAIN_W-1:0]     release_step;
    logic [HOLD_CFG_W-1:0] hold_samples;
    logic [DECAY_W-1:0]    decay_step;
  } sng_cfg_t;

  localparam logic [THR_W-1:0]      RST_OPEN_THRESHOLD  = 16'd1642;
  localparam logic [THR_W-1:0]      RST_CLOSE_THRESHOLD = 16'd823;
  localparam logic [GAIN_W-1:0]     RST_ATTACK_STEP     = 17'd55;
  localparam logic [GAIN_W-1:0]     RST_RELEASE_STEP    = 17'd9;
  localparam logic [HOLD_CFG_W-1:0] RST_HOLD_SAMPLES    = 20'd9600;
  localparam logic [DECAY_W-1:0]    RST_DECAY_STEP      = 16'd328;

endpackage

FILE: src/stereo_noise_gate.sv
// A pair goes through the input register, then the result register, to the outputs.
// Throughput: one pair per cycle unless out_stall holds it up; input register and
// result register form a two-stage pipeline; the gain/peak/hold feedback is unpipelined.
// Reset (rst, synchronous): config registers take their defaults, gate state clears.
// Writing gate_enable = 0 clears the gate state at once; disabled samples pass through.
// The config channel is always ready.
module stereo_noise_gate #(
  parameter int SAMPLE_BITS = sng_pkg::SAMPLE_BITS_DEF,
  parameter int HOLD_BITS   = sng_pkg::HOLD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [SAMPLE_BITS-1:0]    left_sample,
  input  logic signed [SAMPLE_BITS-1:0]    right_sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [SAMPLE_BITS-1:0]    left_out,
  output logic signed [SAMPLE_BITS-1:0]    right_out,
  output logic                             gate_is_open,
  output logic [sng_pkg::GAIN_W-1:0]       current_gain,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sng_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sng_pkg::CFG_DATA_W-1:0]   cfg_data
);

  sng_pkg::sng_cfg_t cfg;
  logic              cfg_write;
  logic              cfg_clear;

  logic                          s1_valid;
  logic signed [SAMPLE_BITS-1:0] s1_left;
  logic signed [SAMPLE_BITS-1:0] s1_right;

  logic                          out_load;
  logic                          advance;
  logic                          clear;

  logic signed [SAMPLE_BITS-1:0] core_left;
  logic signed [SAMPLE_BITS-1:0] core_right;
  logic                          core_open;
  logic [sng_pkg::GAIN_W-1:0]    core_gain;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign cfg_clear = cfg_write && (cfg_index == sng_pkg::REG_GATE_ENABLE) && !cfg_data[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gate_enable     <= 1'b0;
      cfg.open_threshold  <= sng_pkg::RST_OPEN_THRESHOLD;
      cfg.close_threshold <= sng_pkg::RST_CLOSE_THRESHOLD;
      cfg.attack_step     <= sng_pkg::RST_ATTACK_STEP;
      cfg.release_step    <= sng_pkg::RST_RELEASE_STEP;
      cfg.hold_samples    <= sng_pkg::RST_HOLD_SAMPLES;
      cfg.decay_step      <= sng_pkg::RST_DECAY_STEP;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sng_pkg::REG_GATE_ENABLE:     cfg.gate_enable     <= cfg_data[0];
        sng_pkg::REG_OPEN_THRESHOLD:  cfg.open_threshold  <= cfg_data[sng_pkg::THR_W-1:0];
        sng_pkg::REG_CLOSE_THRESHOLD: cfg.close_threshold <= cfg_data[sng_pkg::THR_W-1:0];
        sng_pkg::REG_ATTACK_STEP:     cfg.attack_step     <= cfg_data[sng_pkg::GAIN_W-1:0];
        sng_pkg::REG_RELEASE_STEP:    cfg.release_step    <= cfg_data[sng_pkg::GAIN_W-1:0];
        sng_pkg::REG_HOLD_SAMPLES:    cfg.hold_samples    <= cfg_data[sng_pkg::HOLD_CFG_W-1:0];
        sng_pkg::REG_DECAY_STEP:      cfg.decay_step      <= cfg_data[sng_pkg::DECAY_W-1:0];
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  // pipeline control: result register frees up when empty or its transfer completes
  assign out_load = !out_valid || !out_stall;
  assign advance  = s1_valid && out_load;
  assign in_stall = s1_valid && !out_load;
  assign clear    = cfg_clear || (advance && !cfg.gate_enable);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_left  <= left_sample;
      s1_right <= right_sample;
    end
  end

  sng_core #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .HOLD_BITS   (HOLD_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .step         (advance),
    .clear        (clear),
    .left_sample  (s1_left),
    .right_sample (s1_right),
    .left_out     (core_left),
    .right_out    (core_right),
    .gate_is_open (core_open),
    .current_gain (core_gain)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      left_out     <= core_left;
      right_out    <= core_right;
      gate_is_open <= core_open;
      current_gain <= core_gain;
    end
  end

endmodule

FILE: src/sng_core.sv
// Gate state (open flag, peak, gain, hold counter) and the per-sample gain datapath.
module sng_core #(
  parameter int SAMPLE_BITS = sng_pkg::SAMPLE_BITS_DEF,
  parameter int HOLD_BITS   = sng_pkg::HOLD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sng_pkg::sng_cfg_t             cfg,
  input  logic                          step,
  input  logic                          clear,
  input  logic signed [SAMPLE_BITS-1:0] left_sample,
  input  logic signed [SAMPLE_BITS-1:0] right_sample,
  output logic signed [SAMPLE_BITS-1:0] left_out,
  output logic signed [SAMPLE_BITS-1:0] right_out,
  output logic                          gate_is_open,
  output logic [sng_pkg::GAIN_W-1:0]    current_gain
);

  localparam int GW     = sng_pkg::GAIN_W;
  localparam int LVL_W  = SAMPLE_BITS + 8;
  localparam int PEAK_W = SAMPLE_BITS + 9;
  localparam int OCMP_W = (LVL_W > 24) ? LVL_W : 24;
  localparam int CCMP_W = (PEAK_W > 25) ? PEAK_W : 25;
  localparam int HCMP_W = (HOLD_BITS > sng_pkg::HOLD_CFG_W) ? HOLD_BITS : sng_pkg::HOLD_CFG_W;
  localparam int PROD_W = SAMPLE_BITS + GW + 1;

  logic                     open_flag;
  logic signed [PEAK_W-1:0] peak_level;
  logic [GW-1:0]            gain_value;
  logic [HOLD_BITS-1:0]     hold_count;

  logic                     open_flag_next;
  logic signed [PEAK_W-1:0] peak_level_next;
  logic [GW-1:0]            gain_value_next;
  logic [HOLD_BITS-1:0]     hold_count_next;

  logic signed [SAMPLE_BITS:0] sum;
  logic [SAMPLE_BITS:0]        mag;
  logic [LVL_W-1:0]            level;
  logic signed [PEAK_W-1:0]    level_s;
  logic signed [PEAK_W-1:0]    peak_max;
  logic                        open_hit;
  logic                        close_hit;
  logic                        open_mid;
  logic [HOLD_BITS-1:0]        hold_base;
  logic                        hold_past;
  logic [GW:0]                 gain_sum;
  logic signed [PROD_W-1:0]    prod_l;
  logic signed [PROD_W-1:0]    prod_r;

  always_comb begin
    sum      = (SAMPLE_BITS + 1)'(left_sample) + (SAMPLE_BITS + 1)'(right_sample);
    mag      = sum[SAMPLE_BITS] ? (SAMPLE_BITS + 1)'(-sum) : sum;
    level    = {mag, 7'b0};
    level_s  = $signed({1'b0, level});

    open_hit  = OCMP_W'(level) > OCMP_W'({cfg.open_threshold, 8'b0});
    open_mid  = open_flag | open_hit;
    // close test looks at the peak from before this sample
    close_hit = CCMP_W'(peak_level) < $signed(CCMP_W'({cfg.close_threshold, 8'b0}));
    open_flag_next = open_mid & ~close_hit;

    peak_max        = (peak_level > level_s) ? peak_level : level_s;
    peak_level_next = peak_max - $signed(PEAK_W'(cfg.decay_step));

    hold_base       = (open_mid & close_hit) ? '0 : hold_count;
    hold_count_next = hold_base;
    gain_value_next = gain_value;
    gain_sum        = (GW + 1)'(gain_value) + (GW + 1)'(cfg.attack_step);
    hold_past       = 1'b0;
    if (open_flag_next) begin
      gain_value_next = (gain_sum > (GW + 1)'(sng_pkg::GAIN_ONE)) ? sng_pkg::GAIN_ONE
                                                                 : gain_sum[GW-1:0];
    end else begin
      if (hold_base != {HOLD_BITS{1'b1}}) begin
        hold_count_next = hold_base + HOLD_BITS'(1);
      end
      hold_past = HCMP_W'(hold_count_next) > HCMP_W'(cfg.hold_samples);
      if (hold_past) begin
        gain_value_next = (gain_value > cfg.release_step) ? gain_value - cfg.release_step
                                                          : '0;
      end
    end

    prod_l = PROD_W'(left_sample) * PROD_W'($signed({1'b0, gain_value_next}));
    prod_r = PROD_W'(right_sample) * PROD_W'($signed({1'b0, gain_value_next}));

    if (cfg.gate_enable) begin
      left_out     = prod_l[16 +: SAMPLE_BITS];
      right_out    = prod_r[16 +: SAMPLE_BITS];
      gate_is_open = open_flag_next;
      current_gain = gain_value_next;
    end else begin
      left_out     = left_sample;
      right_out    = right_sample;
      gate_is_open = 1'b0;
      current_gain = sng_pkg::GAIN_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      open_flag  <= 1'b0;
      peak_level <= '0;
      gain_value <= '0;
      hold_count <= '0;
    end else if (step) begin
      open_flag  <= open_flag_next;
      peak_level <= peak_level_next;
      gain_value <= gain_value_next;
      hold_count <= hold_count_next;
    end
  end

  a_gain_bound: assert property (@(posedge clk) disable iff (rst)
    gain_value <= sng_pkg::GAIN_ONE)
    else $error("gain above unity");

  a_clear_state: assert property (@(posedge clk)
    clear |=> (gain_value == '0) && !open_flag && (peak_level == '0) && (hold_count == '0))
    else $error("state not cleared");

  a_attack_rises: assert property (@(posedge clk) disable iff (rst)
    (step && !clear && open_flag_next) |=> gain_value >= $past(gain_value))
    else $error("gain fell while open");

  a_hold_resets: assert property (@(posedge clk) disable iff (rst)
    (step && !clear && open_mid && close_hit) |=> hold_count <= HOLD_BITS'(1))
    else $error("hold counter not restarted on close");

endmodule
